FILE: src/line_pixel_stepper_unit_macros.svh
// Assertion helpers used by the checker lps_checker.
// Both sample on the rising edge of clk and are quiet while arst_n is low.
`ifndef LINE_PIXEL_STEPPER_UNIT_MACROS_SVH
`define LINE_PIXEL_STEPPER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lps assertion failed");

// Next-cycle implication.
`define LPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lps assertion failed");

`endif

FILE: src/lps_pkg.sv
package lps_pkg;

	localparam int COORD_BITS   = 12;
	localparam int ERR_BITS     = COORD_BITS + 3;
	localparam int STR_BITS     = COORD_BITS + 2;
	localparam int ROW_BITS     = 13;
	localparam int WORD_BITS    = ROW_BITS + COORD_BITS + 1;
	localparam int ADDR_BITS    = 32;
	localparam int COLOR_BITS   = 32;
	localparam int REG_IDX_BITS = 2;

	typedef logic [COORD_BITS-1:0] coord_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_FRAME_BASE = 2'd0,
		REG_ROW_PIXELS = 2'd1,
		REG_DRAW_COLOR = 2'd2
	} reg_idx_t;

	localparam logic [ADDR_BITS-1:0]  FRAME_BASE_RST = 32'hac00_1000;
	localparam logic [ROW_BITS-1:0]   ROW_PIXELS_RST = 13'd1536;
	localparam logic [COLOR_BITS-1:0] DRAW_COLOR_RST = 32'h0;

	typedef struct packed {
		logic [ADDR_BITS-1:0]  frame_base;
		logic [ROW_BITS-1:0]   row_pixels;
		logic [COLOR_BITS-1:0] draw_color;
	} cfg_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pix_t;

endpackage

FILE: src/lps_in_if.sv
interface lps_in_if
	import lps_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   operation;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;

	modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
	modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

FILE: src/lps_out_if.sv
interface lps_out_if
	import lps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	coord_t                pixel_x;
	coord_t                pixel_y;
	logic [ADDR_BITS-1:0]  pixel_address;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
		output ready);
endinterface

FILE: src/lps_cfg_if.sv
interface lps_cfg_if
	import lps_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [REG_IDX_BITS-1:0] index;
	logic [ADDR_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/lps_walker.sv
module lps_walker
	import lps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	lps_in_if.sink  in_ch,
	output logic    pix_valid,
	output pix_t    pix,
	input  logic    pix_ready
);

	function automatic coord_t move_coord(input coord_t c, input logic negative);
		return negative ? c - 1'b1 : c + 1'b1;
	endfunction

	// input register
	logic   valid_s1;
	logic   op_s1;
	coord_t xs_s1, ys_s1, xe_s1, ye_s1;

	// line state
	coord_t                 cur_x_q, cur_y_q;
	logic [ERR_BITS-1:0]    err_q;
	logic [ERR_BITS-1:0]    diag_q;
	logic [STR_BITS-1:0]    straight_q;
	coord_t                 steps_q;
	logic                   xneg_q, yneg_q, xmaj_q, active_q;

	// pixel register
	logic valid_s2;
	pix_t pix_s2;

	logic en_s1, en_s2, fire;

	logic                xneg, yneg, xmaj;
	coord_t              dx, dy, major, minor;
	logic [ERR_BITS-1:0] err_start, diag_start;
	logic [STR_BITS-1:0] straight_start;

	coord_t              nx, ny, steps_n;
	logic [ERR_BITS-1:0] err_n;
	pix_t                pix_n;

	assign en_s2       = !valid_s2 || pix_ready;
	assign en_s1       = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;
	assign fire        = valid_s1 && en_s2;

	// line set-up
	always_comb begin
		xneg  = xe_s1 < xs_s1;
		yneg  = ye_s1 < ys_s1;
		dx    = xneg ? xs_s1 - xe_s1 : xe_s1 - xs_s1;
		dy    = yneg ? ys_s1 - ye_s1 : ye_s1 - ys_s1;
		xmaj  = dx > dy;
		major = xmaj ? dx : dy;
		minor = xmaj ? dy : dx;
		err_start      = ERR_BITS'({minor, 1'b0}) - ERR_BITS'(major);
		diag_start     = ERR_BITS'({minor, 1'b0}) - ERR_BITS'({major, 1'b0});
		straight_start = STR_BITS'({minor, 1'b0});
	end

	// one step along the line
	always_comb begin
		nx = cur_x_q;
		ny = cur_y_q;
		if (!err_q[ERR_BITS-1]) begin
			if (xmaj_q) begin
				ny = move_coord(ny, yneg_q);
			end else begin
				nx = move_coord(nx, xneg_q);
			end
			err_n = err_q + diag_q;
		end else begin
			err_n = err_q + ERR_BITS'(straight_q);
		end
		if (xmaj_q) begin
			nx = move_coord(nx, xneg_q);
		end else begin
			ny = move_coord(ny, yneg_q);
		end
		steps_n = steps_q - 1'b1;
	end

	always_comb begin
		if (op_s1 == OP_START) begin
			pix_n.x    = xs_s1;
			pix_n.y    = ys_s1;
			pix_n.last = major == '0;
		end else begin
			pix_n.x    = nx;
			pix_n.y    = ny;
			pix_n.last = steps_n == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_ch.valid) begin
			op_s1 <= in_ch.operation;
			xs_s1 <= in_ch.x_start;
			ys_s1 <= in_ch.y_start;
			xe_s1 <= in_ch.x_end;
			ye_s1 <= in_ch.y_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			err_q      <= '0;
			diag_q     <= '0;
			straight_q <= '0;
			steps_q    <= '0;
			xneg_q     <= 1'b0;
			yneg_q     <= 1'b0;
			xmaj_q     <= 1'b0;
			active_q   <= 1'b0;
		end else if (fire) begin
			if (op_s1 == OP_START) begin
				cur_x_q    <= xs_s1;
				cur_y_q    <= ys_s1;
				err_q      <= err_start;
				diag_q     <= diag_start;
				straight_q <= straight_start;
				steps_q    <= major;
				xneg_q     <= xneg;
				yneg_q     <= yneg;
				xmaj_q     <= xmaj;
				active_q   <= major != '0;
			end else if (active_q) begin
				cur_x_q  <= nx;
				cur_y_q  <= ny;
				err_q    <= err_n;
				steps_q  <= steps_n;
				active_q <= steps_n != '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			// a step with no line in progress leaves a bubble
			valid_s2 <= valid_s1 && (op_s1 == OP_START || active_q);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pix_s2 <= pix_n;
		end
	end

	assign pix_valid = valid_s2;
	assign pix       = pix_s2;

endmodule

FILE: src/lps_addr.sv
module lps_addr
	import lps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pix_valid,
	input  pix_t      pix,
	output logic      pix_ready,
	lps_out_if.source out_ch
);

	logic [ROW_BITS+COORD_BITS-1:0] prod;
	logic [WORD_BITS-1:0]           word;
	logic [ADDR_BITS-1:0]           addr;
	logic                           en_o;

	logic                  valid_q;
	coord_t                x_q, y_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [COLOR_BITS-1:0] color_q;
	logic                  last_q;

	always_comb begin
		prod = (ROW_BITS+COORD_BITS)'(cfg.row_pixels) * (ROW_BITS+COORD_BITS)'(pix.y);
		word = WORD_BITS'(prod) + WORD_BITS'(pix.x);
		addr = cfg.frame_base + ADDR_BITS'({word, 2'b00});
	end

	assign en_o      = !valid_q || out_ch.ready;
	assign pix_ready = en_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_o) begin
			valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && pix_valid) begin
			x_q     <= pix.x;
			y_q     <= pix.y;
			addr_q  <= addr;
			color_q <= cfg.draw_color;
			last_q  <= pix.last;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.pixel_x       = x_q;
	assign out_ch.pixel_y       = y_q;
	assign out_ch.pixel_address = addr_q;
	assign out_ch.pixel_color   = color_q;
	assign out_ch.last_pixel    = last_q;

endmodule

FILE: src/line_pixel_stepper_unit.sv
// Bresenham line engine, all octants.
// in_ch: operation START loads two endpoints and yields the first pixel;
//   operation STEP yields the next pixel of the active line, or nothing
//   when no line is active. A START during a line drops that line.
// out_ch: one pixel per result with x, y, byte address
//   frame_base + 4*(row_pixels*y + x), the draw colour, and last_pixel on
//   the second endpoint.
// cfg_ch: register writes (0 frame_base, 1 row_pixels, 2 draw_color), always
//   ready; write only while no pixel is outstanding.
// Path: a pixel reaches out_ch through the input register, walker register
//   and address register.
// Throughput: one item per cycle while out_ch is ready; the walker's error
//   update and the 13x12 address multiply each take one register stage.
// Reset: pipeline empty, no line active, registers at their reset values.
// Stall: when out_ch is not ready the output holds, the stages fill up and
//   in_ch.ready falls once every stage is full.
module line_pixel_stepper_unit
	import lps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	lps_in_if.sink    in_ch,
	lps_out_if.source out_ch,
	lps_cfg_if.sink   cfg_ch
);

	cfg_t cfg_q;
	logic pix_valid, pix_ready;
	pix_t pix;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base <= FRAME_BASE_RST;
			cfg_q.row_pixels <= ROW_PIXELS_RST;
			cfg_q.draw_color <= DRAW_COLOR_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_FRAME_BASE: cfg_q.frame_base <= cfg_ch.data;
				REG_ROW_PIXELS: cfg_q.row_pixels <= cfg_ch.data[ROW_BITS-1:0];
				REG_DRAW_COLOR: cfg_q.draw_color <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	lps_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready)
	);

	lps_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready),
		.out_ch    (out_ch)
	);

endmodule

FILE: src/lps_checker.sv
`include "line_pixel_stepper_unit_macros.svh"

module lps_checker
	import lps_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_operation,
	input logic                  out_valid,
	input logic                  out_ready,
	input coord_t                out_x,
	input coord_t                out_y,
	input logic [ADDR_BITS-1:0]  out_address,
	input logic [COLOR_BITS-1:0] out_color,
	input logic                  out_last
);

	// a stalled pixel stays put
	`LPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_address) && $stable(out_color) && $stable(out_last))

	// a ready sink never holds back the input side
	`LPS_ASSERT_IMPL(a_in_flows, out_ready, in_ready)

	// a start transfer shows its pixel when out_ready stays high while it passes the input and walker registers
	`LPS_ASSERT_NEXT(a_start_latency, in_valid && in_ready && (in_operation == OP_START) ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind line_pixel_stepper_unit lps_checker u_lps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_operation (in_ch.operation),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_x        (out_ch.pixel_x),
	.out_y        (out_ch.pixel_y),
	.out_address  (out_ch.pixel_address),
	.out_color    (out_ch.pixel_color),
	.out_last     (out_ch.last_pixel)
);
